>>> sv/pendulum_state_propagator_unit_macros.svh
// assertion macros shared by the pendulum state propagator rtl
// expects signals named clock and reset in the including module
`ifndef PENDULUM_STATE_PROPAGATOR_UNIT_MACROS_SVH
`define PENDULUM_STATE_PROPAGATOR_UNIT_MACROS_SVH

// same-cycle implication
`define PSP_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/psp_pkg.sv
// shared types, widths and constants of the pendulum state propagator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

   localparam int DATA_W   = 32;
   localparam int CFG_W    = 24;
   localparam int TIME_W   = 22;
   localparam int IDX_W    = 8;
   localparam int COEF_W   = 37;
   localparam int K_W      = 7;
   localparam int P_W      = CFG_W + TIME_W;
   localparam int R_W      = 41;
   localparam int CX_W     = 34;
   localparam int Z_W      = 33;
   localparam int MAG_W    = 32;
   localparam int HALF_W   = MAG_W / 2;
   localparam int PP_W     = COEF_W + HALF_W + 1;
   localparam int PROD_W   = COEF_W + MAG_W + 1;
   localparam int TERM_W   = 42;
   localparam int STAGES   = 30;
   localparam int LANES    = 4;

   localparam logic [IDX_W-1:0] CSR_OMEGA     = IDX_W'(0);
   localparam logic [IDX_W-1:0] CSR_OMEGA_INV = IDX_W'(1);

   localparam logic [CFG_W-1:0] OMEGA_RESET     = CFG_W'(3275572);
   localparam logic [CFG_W-1:0] OMEGA_INV_RESET = CFG_W'(335669);

   localparam logic [39:0] LN2_Q40 = 40'hB17217F7D2;
   localparam logic [63:0] RECIP_FULL = (64'd1 << 56) / 64'hB17217F7D2;
   localparam logic [16:0] RECIP_LN2 = RECIP_FULL[16:0];
   localparam logic signed [CX_W-1:0] GAIN_INV_Q30 = CX_W'(1296540104);

   typedef struct packed {
      logic signed [COEF_W-1:0] s;
      logic signed [COEF_W-1:0] t;
      logic signed [COEF_W-1:0] sv;
      logic signed [COEF_W-1:0] tv;
   } coef_type;

   typedef struct packed {
      coef_type             x;
      coef_type             y;
      logic [K_W-1:0]       k;
   } side_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_end;
      logic signed [DATA_W-1:0] y_end;
      logic signed [DATA_W-1:0] x_speed_end;
      logic signed [DATA_W-1:0] y_speed_end;
      logic                     saturated;
   } result_type;

   // shift of each rotation stage, steps 4 and 13 repeated
   function automatic int cordic_shift(input int s);
      int r;
      if (s <= 3) r = s + 1;
      else if (s <= 13) r = s;
      else r = s - 1;
      return r;
   endfunction

   // atanh(2^-i) in q.30
   function automatic logic [29:0] atanh_angle(input int i);
      logic [29:0] a;
      case (i)
         1: a = 30'd589812981;
         2: a = 30'd274247419;
         3: a = 30'd134923406;
         4: a = 30'd67196451;
         5: a = 30'd33565361;
         6: a = 30'd16778582;
         7: a = 30'd8388779;
         8: a = 30'd4194325;
         9: a = 30'd2097155;
         default: a = 30'd1 << (30 - i);
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

>>> sv/psp_front.sv
// front stages: angle product, range reduction by ln2 and start coefficients
// depends on psp_pkg
`timescale 1ns / 1ps
`default_nettype none

module psp_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           adv,
   input  wire logic                           in_valid,
   input  wire logic signed [psp_pkg::DATA_W-1:0] x_start,
   input  wire logic signed [psp_pkg::DATA_W-1:0] y_start,
   input  wire logic signed [psp_pkg::DATA_W-1:0] x_speed_start,
   input  wire logic signed [psp_pkg::DATA_W-1:0] y_speed_start,
   input  wire logic [psp_pkg::TIME_W-1:0]     elapsed_time,
   input  wire logic [psp_pkg::CFG_W-1:0]      omega,
   input  wire logic [psp_pkg::CFG_W-1:0]      omega_inverse,
   output logic                                out_valid,
   output logic signed [psp_pkg::Z_W-1:0]      out_z,
   output psp_pkg::side_type                   out_side
);
   import psp_pkg::*;

   localparam int MP_W = DATA_W + CFG_W + 1;

   logic signed [MP_W-1:0] qx_prod, qy_prod, wx_prod, wy_prod;
   logic signed [COEF_W-1:0] qx, qy, wx, wy, px, py, vx, vy;
   logic [38:0] kest_prod;
   logic [46:0] kl_prod;
   logic [R_W-1:0] r_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [P_W-1:0] p1_ff, p2_ff;
   logic signed [MP_W-1:0] qx1_ff, qy1_ff, wx1_ff, wy1_ff;
   logic signed [DATA_W-1:0] px1_ff, py1_ff, vx1_ff, vy1_ff;
   logic [K_W-1:0] k2_ff, k3_ff, k_out_ff;
   coef_type cx2_ff, cy2_ff, cx3_ff, cy3_ff, cx4_ff, cy4_ff;
   logic [R_W-1:0] r3_ff;
   logic signed [Z_W-1:0] z4_ff;

   assign qx_prod = x_speed_start * $signed({1'b0, omega_inverse});
   assign qy_prod = y_speed_start * $signed({1'b0, omega_inverse});
   assign wx_prod = x_start * $signed({1'b0, omega});
   assign wy_prod = y_start * $signed({1'b0, omega});

   // round half up by 2^20
   assign qx = COEF_W'((qx1_ff + MP_W'(1 << 19)) >>> 20);
   assign qy = COEF_W'((qy1_ff + MP_W'(1 << 19)) >>> 20);
   assign wx = COEF_W'((wx1_ff + MP_W'(1 << 19)) >>> 20);
   assign wy = COEF_W'((wy1_ff + MP_W'(1 << 19)) >>> 20);
   assign px = COEF_W'(px1_ff);
   assign py = COEF_W'(py1_ff);
   assign vx = COEF_W'(vx1_ff);
   assign vy = COEF_W'(vy1_ff);

   // quotient estimate never above the true one, at most one short
   assign kest_prod = 39'(p1_ff[P_W-1:24]) * 39'(RECIP_LN2);
   assign kl_prod   = 47'(k2_ff) * 47'(LN2_Q40);
   assign r_in      = R_W'(47'(p2_ff) - kl_prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff  <= P_W'(omega) * P_W'(elapsed_time);
         qx1_ff <= qx_prod;
         qy1_ff <= qy_prod;
         wx1_ff <= wx_prod;
         wy1_ff <= wy_prod;
         px1_ff <= x_start;
         py1_ff <= y_start;
         vx1_ff <= x_speed_start;
         vy1_ff <= y_speed_start;

         p2_ff     <= p1_ff;
         k2_ff     <= kest_prod[38:32];
         cx2_ff.s  <= px + qx;
         cx2_ff.t  <= px - qx;
         cx2_ff.sv <= wx + vx;
         cx2_ff.tv <= wx - vx;
         cy2_ff.s  <= py + qy;
         cy2_ff.t  <= py - qy;
         cy2_ff.sv <= wy + vy;
         cy2_ff.tv <= wy - vy;

         r3_ff  <= r_in;
         k3_ff  <= k2_ff;
         cx3_ff <= cx2_ff;
         cy3_ff <= cy2_ff;

         if (r3_ff >= R_W'(LN2_Q40)) begin
            k_out_ff <= k3_ff + K_W'(1);
            z4_ff    <= Z_W'((r3_ff - R_W'(LN2_Q40)) >> 10);
         end else begin
            k_out_ff <= k3_ff;
            z4_ff    <= Z_W'(r3_ff >> 10);
         end
         cx4_ff <= cx3_ff;
         cy4_ff <= cy3_ff;
      end
   end

   assign out_valid  = v4_ff;
   assign out_z      = z4_ff;
   assign out_side.x = cx4_ff;
   assign out_side.y = cy4_ff;
   assign out_side.k = k_out_ff;

endmodule

`default_nettype wire

>>> sv/psp_cordic.sv
// pipelined hyperbolic cordic, one rotation per register stage
// depends on psp_pkg
`timescale 1ns / 1ps
`default_nettype none

module psp_cordic (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic                      in_valid,
   input  wire logic signed [psp_pkg::Z_W-1:0] in_z,
   input  wire psp_pkg::side_type         in_side,
   output logic                           out_valid,
   output logic signed [psp_pkg::CX_W-1:0] out_cx,
   output logic signed [psp_pkg::CX_W-1:0] out_cy,
   output psp_pkg::side_type              out_side
);
   import psp_pkg::*;

   logic                   v_src  [STAGES];
   logic signed [CX_W-1:0] cx_src [STAGES];
   logic signed [CX_W-1:0] cy_src [STAGES];
   logic signed [Z_W-1:0]  z_src  [STAGES];
   side_type               sd_src [STAGES];

   logic                   v_ff   [STAGES];
   logic signed [CX_W-1:0] cx_ff  [STAGES];
   logic signed [CX_W-1:0] cy_ff  [STAGES];
   logic signed [Z_W-1:0]  z_ff   [STAGES];
   side_type               sd_ff  [STAGES];

   assign v_src[0]  = in_valid;
   assign cx_src[0] = GAIN_INV_Q30;
   assign cy_src[0] = '0;
   assign z_src[0]  = in_z;
   assign sd_src[0] = in_side;

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      localparam int SH = cordic_shift(g);
      localparam logic signed [Z_W-1:0] ANG = Z_W'(atanh_angle(SH));

      logic signed [CX_W-1:0] dx, dy;

      assign dx = cy_src[g] >>> SH;
      assign dy = cx_src[g] >>> SH;

      if (g < STAGES - 1) begin : g_link
         assign v_src[g+1]  = v_ff[g];
         assign cx_src[g+1] = cx_ff[g];
         assign cy_src[g+1] = cy_ff[g];
         assign z_src[g+1]  = z_ff[g];
         assign sd_src[g+1] = sd_ff[g];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (adv) begin
            v_ff[g] <= v_src[g];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (z_src[g] >= 0) begin
               cx_ff[g] <= cx_src[g] + dx;
               cy_ff[g] <= cy_src[g] + dy;
               z_ff[g]  <= z_src[g] - ANG;
            end else begin
               cx_ff[g] <= cx_src[g] - dx;
               cy_ff[g] <= cy_src[g] - dy;
               z_ff[g]  <= z_src[g] + ANG;
            end
            sd_ff[g] <= sd_src[g];
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_cx    = cx_ff[STAGES-1];
   assign out_cy    = cy_ff[STAGES-1];
   assign out_side  = sd_ff[STAGES-1];

endmodule

`default_nettype wire

>>> sv/psp_combine.sv
// output stages: split products, scaling by 2^k, rounding and saturation
// depends on psp_pkg
`timescale 1ns / 1ps
`default_nettype none

module psp_combine (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire logic                       in_valid,
   input  wire logic signed [psp_pkg::CX_W-1:0] in_cx,
   input  wire logic signed [psp_pkg::CX_W-1:0] in_cy,
   input  wire psp_pkg::side_type          in_side,
   output logic                            out_valid,
   output psp_pkg::result_type             out_result
);
   import psp_pkg::*;

   localparam logic signed [TERM_W-1:0] CLAMP_POS = TERM_W'(1) <<< 40;
   localparam logic signed [TERM_W-1:0] CLAMP_NEG = -(TERM_W'(1) <<< 40);
   localparam logic signed [TERM_W:0]   DATA_MAX = (TERM_W+1)'((64'd1 << (DATA_W-1)) - 1);
   localparam logic signed [TERM_W:0]   DATA_MIN = -(TERM_W+1)'(64'd1 << (DATA_W-1));

   // growing term, times 2^k / 2^31, clamped where the sum cannot fit anyway
   function automatic logic signed [TERM_W-1:0] scale_up(
      input logic signed [PROD_W-1:0] t, input logic [K_W-1:0] k);
      logic [5:0] sh;
      logic [4:0] s1;
      logic signed [PROD_W-1:0] chk;
      logic signed [PROD_W:0] r;
      logic ovf;
      logic signed [TERM_W-1:0] val;
      sh = '0;
      s1 = '0;
      chk = '0;
      r = '0;
      if (k >= K_W'(31)) begin
         sh = 6'(k - K_W'(31));
         if (sh > 6'd40) begin
            ovf = (t != '0);
         end else begin
            chk = t >>> (6'd40 - sh);
            ovf = !(chk == '0 || chk == '1);
         end
         val = TERM_W'(t <<< sh);
      end else begin
         s1 = 5'(K_W'(31) - k);
         r = ((PROD_W+1)'(t) + ((PROD_W+1)'(1) <<< (s1 - 5'd1))) >>> s1;
         ovf = !(r[PROD_W:TERM_W-1] == '0 || r[PROD_W:TERM_W-1] == '1);
         val = r[TERM_W-1:0];
      end
      if (ovf) val = t[PROD_W-1] ? CLAMP_NEG : CLAMP_POS;
      return val;
   endfunction

   // decaying term, divided by 2^(k+31)
   function automatic logic signed [TERM_W-1:0] scale_down(
      input logic signed [PROD_W-1:0] t, input logic [K_W-1:0] k);
      logic [7:0] s2;
      logic signed [PROD_W+1:0] r;
      logic signed [TERM_W-1:0] val;
      s2 = 8'(k) + 8'd31;
      r = '0;
      if (s2 >= 8'(PROD_W + 1)) begin
         val = '0;
      end else begin
         r = ((PROD_W+2)'(t) + ((PROD_W+2)'(1) <<< (s2 - 8'd1))) >>> s2;
         val = r[TERM_W-1:0];
      end
      return val;
   endfunction

   logic [MAG_W-1:0] ep_in, em_in;
   logic signed [COEF_W-1:0] ca_in [LANES];
   logic signed [COEF_W-1:0] cb_in [LANES];
   logic signed [TERM_W:0]   sum_in [LANES];
   logic signed [DATA_W-1:0] val_in [LANES];
   logic [LANES-1:0] sat_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [MAG_W-1:0] ep1_ff, em1_ff;
   logic [K_W-1:0] k1_ff, k2_ff, k3_ff;
   logic signed [COEF_W-1:0] ca1_ff [LANES];
   logic signed [COEF_W-1:0] cb1_ff [LANES];
   logic signed [PP_W-1:0] pal_ff [LANES];
   logic signed [PP_W-1:0] pah_ff [LANES];
   logic signed [PP_W-1:0] pbl_ff [LANES];
   logic signed [PP_W-1:0] pbh_ff [LANES];
   logic signed [PROD_W-1:0] ta_ff [LANES];
   logic signed [PROD_W-1:0] tb_ff [LANES];
   logic signed [TERM_W-1:0] c1_ff [LANES];
   logic signed [TERM_W-1:0] c2_ff [LANES];
   result_type res_ff;

   assign ep_in = MAG_W'(in_cx + in_cy);
   assign em_in = MAG_W'(in_cx - in_cy);

   assign ca_in[0] = in_side.x.s;
   assign cb_in[0] = in_side.x.t;
   assign ca_in[1] = in_side.y.s;
   assign cb_in[1] = in_side.y.t;
   assign ca_in[2] = in_side.x.sv;
   assign cb_in[2] = in_side.x.tv;
   assign ca_in[3] = in_side.y.sv;
   assign cb_in[3] = in_side.y.tv;

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      // velocity lanes subtract the decaying term
      if (j < 2) begin : g_pos
         assign sum_in[j] = (TERM_W+1)'(c1_ff[j]) + (TERM_W+1)'(c2_ff[j]);
      end else begin : g_vel
         assign sum_in[j] = (TERM_W+1)'(c1_ff[j]) - (TERM_W+1)'(c2_ff[j]);
      end
      assign sat_in[j] = !(sum_in[j][TERM_W:DATA_W-1] == '0 ||
                           sum_in[j][TERM_W:DATA_W-1] == '1);
      assign val_in[j] = !sat_in[j] ? sum_in[j][DATA_W-1:0] :
                         sum_in[j][TERM_W] ? DATA_W'(DATA_MIN) : DATA_W'(DATA_MAX);

      always_ff @(posedge clock) begin
         if (adv) begin
            ca1_ff[j] <= ca_in[j];
            cb1_ff[j] <= cb_in[j];
            pal_ff[j] <= PP_W'(ca1_ff[j]) * $signed(PP_W'({1'b0, ep1_ff[HALF_W-1:0]}));
            pah_ff[j] <= PP_W'(ca1_ff[j]) * $signed(PP_W'({1'b0, ep1_ff[MAG_W-1:HALF_W]}));
            pbl_ff[j] <= PP_W'(cb1_ff[j]) * $signed(PP_W'({1'b0, em1_ff[HALF_W-1:0]}));
            pbh_ff[j] <= PP_W'(cb1_ff[j]) * $signed(PP_W'({1'b0, em1_ff[MAG_W-1:HALF_W]}));
            ta_ff[j]  <= (PROD_W'(pah_ff[j]) <<< HALF_W) + PROD_W'(pal_ff[j]);
            tb_ff[j]  <= (PROD_W'(pbh_ff[j]) <<< HALF_W) + PROD_W'(pbl_ff[j]);
            c1_ff[j]  <= scale_up(ta_ff[j], k3_ff);
            c2_ff[j]  <= scale_down(tb_ff[j], k3_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ep1_ff <= ep_in;
         em1_ff <= em_in;
         k1_ff  <= in_side.k;
         k2_ff  <= k1_ff;
         k3_ff  <= k2_ff;
         res_ff.x_end       <= val_in[0];
         res_ff.y_end       <= val_in[1];
         res_ff.x_speed_end <= val_in[2];
         res_ff.y_speed_end <= val_in[3];
         res_ff.saturated   <= |sat_in;
      end
   end

   assign out_valid  = v5_ff;
   assign out_result = res_ff;

endmodule

`default_nettype wire

>>> sv/pendulum_state_propagator_unit.sv
// Linear inverted pendulum state propagator. One start state per beat enters on the req
// stream and the state after elapsed_time leaves on the rsp stream, one result per item, in
// order. It has 4 range-reduction stages, 30 cordic rotation stages and 5 product and rounding
// stages. Throughput is one item per clock, but when rsp_tready is low with a result pending
// the whole pipeline holds and req_tready drops. The user must write omega and omega_inverse
// on the csr channel (index 0 and 1) only while no item is in flight; not enforced by the block.
// depends on psp_pkg, psp_front, psp_cordic, psp_combine and the macro header
`timescale 1ns / 1ps
`default_nettype none

`include "pendulum_state_propagator_unit_macros.svh"

module pendulum_state_propagator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // x_start, y_start, x_speed_start, y_speed_start, elapsed_time, zero pad
   input  wire logic [151:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // x_end, y_end, x_speed_end, y_speed_end
   output logic [127:0]     rsp_tdata,
   // saturated
   output logic [0:0]       rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [psp_pkg::IDX_W-1:0] csr_index,
   input  wire logic [psp_pkg::CFG_W-1:0] csr_data
);
   import psp_pkg::*;

   logic adv;
   logic [CFG_W-1:0] omega_ff, omega_inv_ff;
   logic front_valid, cordic_valid, comb_valid;
   logic signed [Z_W-1:0] front_z;
   side_type front_side, cordic_side;
   logic signed [CX_W-1:0] cordic_cx, cordic_cy;
   result_type comb_result;

   assign adv        = !comb_valid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         omega_ff     <= OMEGA_RESET;
         omega_inv_ff <= OMEGA_INV_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OMEGA:     omega_ff     <= csr_data;
            CSR_OMEGA_INV: omega_inv_ff <= csr_data;
            default: ;
         endcase
      end
   end

   psp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (req_tvalid),
      .x_start       ($signed(req_tdata[31:0])),
      .y_start       ($signed(req_tdata[63:32])),
      .x_speed_start ($signed(req_tdata[95:64])),
      .y_speed_start ($signed(req_tdata[127:96])),
      .elapsed_time  (req_tdata[149:128]),
      .omega         (omega_ff),
      .omega_inverse (omega_inv_ff),
      .out_valid     (front_valid),
      .out_z         (front_z),
      .out_side      (front_side)
   );

   psp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_z      (front_z),
      .in_side   (front_side),
      .out_valid (cordic_valid),
      .out_cx    (cordic_cx),
      .out_cy    (cordic_cy),
      .out_side  (cordic_side)
   );

   psp_combine u_combine (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (cordic_valid),
      .in_cx      (cordic_cx),
      .in_cy      (cordic_cy),
      .in_side    (cordic_side),
      .out_valid  (comb_valid),
      .out_result (comb_result)
   );

   assign rsp_tvalid = comb_valid;
   assign rsp_tdata  = {comb_result.y_speed_end, comb_result.x_speed_end,
                        comb_result.y_end, comb_result.x_end};
   assign rsp_tuser  = comb_result.saturated;

   `PSP_ASSERT_NEXT(a_reset_empty, 1'b1, !$past(reset) || !rsp_tvalid, "result right after reset")
   `PSP_ASSERT_NEXT(a_omega_wr, csr_valid && csr_ready && csr_index == CSR_OMEGA, omega_ff == $past(csr_data), "omega write lost")
   `PSP_ASSERT_NEXT(a_omega_inv_wr, csr_valid && csr_ready && csr_index == CSR_OMEGA_INV, omega_inv_ff == $past(csr_data), "omega_inverse write lost")
   `PSP_ASSERT_IMPLY(a_sat_extreme, rsp_tvalid && rsp_tuser[0], rsp_tdata[31:0] == 32'h80000000 || rsp_tdata[31:0] == 32'h7fffffff || rsp_tdata[63:32] == 32'h80000000 || rsp_tdata[63:32] == 32'h7fffffff || rsp_tdata[95:64] == 32'h80000000 || rsp_tdata[95:64] == 32'h7fffffff || rsp_tdata[127:96] == 32'h80000000 || rsp_tdata[127:96] == 32'h7fffffff, "saturated flag without clipped value")

endmodule

`default_nettype wire
